>>> src/mrmr_pkg.sv
package mrmr_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int CH_W        = 3;
  localparam int SAMPLE_W    = 12;
  localparam int ADDR_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COUNT_W     = 16;
  localparam int N_W         = COUNT_W + 1;
  localparam int FS_W        = 14;
  localparam int MV_W        = 14;
  localparam int PROD_W      = SAMPLE_BITS + FS_W;
  localparam int DIV_CNT_W   = $clog2(SAMPLE_BITS + 1);

  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] RPR_RESET = COUNT_W'(4000);
  localparam logic [FS_W-1:0]    FS_RESET  = FS_W'(3300);

  // channel limit, one bit wider than the channel field
  localparam logic [CH_W:0]       CH_LIMIT  = (CH_W + 1)'(CHANNELS);
  localparam logic [CH_W-1:0]     CH_FINAL  = CH_W'(CHANNELS - 1);
  localparam logic [ADDR_W-1:0]   ADDR_LAST = ADDR_W'(CHANNELS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS_PER_REPORT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_MV     = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WRITE,
    ST_RPT_READ,
    ST_RPT_MUL,
    ST_RPT_LOAD
  } state_t;

  typedef struct packed {
    logic                   rd;
    logic [ADDR_W-1:0]      raddr;
    logic                   wr;
    logic [ADDR_W-1:0]      waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic                   clr;
  } ram_req_t;

endpackage

>>> src/mrmr_mean_ram.sv
module mrmr_mean_ram
  import mrmr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ram_req_t               req,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]    valid;
  logic [SAMPLE_BITS-1:0] rd_word;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rd_word <= mem[req.raddr];
    end
  end

  // an entry not written since reset or the last report reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.clr) begin
        valid <= '0;
      end else if (req.wr) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.rd) begin
        rd_valid <= valid[req.raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

>>> src/mrmr_div.sv
module mrmr_div
  import mrmr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] dividend,
  input  logic [N_W-1:0]         divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  logic                   busy;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [SAMPLE_BITS-1:0] acc;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS:0]   shifted;
  logic [N_W-1:0]         diff;
  logic                   fits;

  // restoring division, one quotient bit a cycle, quotient shifts into acc
  always_comb begin
    shifted = {rem, acc[SAMPLE_BITS-1]};
    fits    = N_W'(shifted) >= divisor;
    diff    = N_W'(shifted) - divisor;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      acc <= {acc[SAMPLE_BITS-2:0], fits};
      rem <= fits ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(SAMPLE_BITS - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(SAMPLE_BITS - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = acc;

endmodule

>>> src/mrmr_scale.sv
module mrmr_scale
  import mrmr_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] mean,
  input  logic [FS_W-1:0]        full_scale_mv,
  output logic [MV_W-1:0]        millivolts
);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(mean) * PROD_W'(full_scale_mv);

  // drop the fraction below one millivolt
  always_ff @(posedge clk) begin
    if (en) begin
      millivolts <= prod[SAMPLE_BITS +: MV_W];
    end
  end

endmodule

>>> src/multichannel_running_mean_report.sv
// channel   | direction | word                                      | accepted when
// s_axis    | in        | channel, sample                           | tvalid & tready
// m_axis    | out       | report_channel, millivolts; tlast at end  | tvalid & tready
// cfg       | in        | cfg_index selects register, cfg_data      | cfg_valid & cfg_ready
//
// A sample drops s_axis_tready for read, the divide steps, seeing the divider finish and write back;
// no further sample is taken until write back, or the report that follows it, is through.
// A report steps through read, multiply and load per channel, and waits in load while m_axis stalls.
// The serial divider sets how long each sample takes; one sample is in flight at a time.
// Reset clears the means, the round count and restores both registers to defaults.
// The last report word may wait in the output register while the next sample is taken.
module multichannel_running_mean_report
  import mrmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // channel[2:0], sample[14:3], zero[15]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // report_channel[2:0], millivolts[16:3]
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [COUNT_W-1:0]     rounds_per_report;
  logic [FS_W-1:0]        full_scale_mv;
  logic [COUNT_W-1:0]     round_count;
  logic [CH_W-1:0]        ch;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] mean;
  logic                   neg;
  logic [ADDR_W-1:0]      k;

  logic                   out_valid;
  logic [CH_W-1:0]        out_ch;
  logic [MV_W-1:0]        out_mv;
  logic                   out_last;

  ram_req_t               ram_req;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] quotient;
  logic                   scale_en;
  logic [MV_W-1:0]        scaled_mv;

  logic [CH_W-1:0]        in_ch;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic                   in_take;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0] diff_mag;
  logic [SAMPLE_BITS-1:0] mean_next;
  logic [N_W-1:0]         n;
  logic [N_W-1:0]         count_inc;
  logic                   round_end;
  logic                   report;
  logic                   load;
  logic                   out_free;

  assign in_ch  = s_axis_tdata[CH_W-1:0];
  assign in_smp = s_axis_tdata[CH_W +: SAMPLE_BITS];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // signed difference, magnitude to the divider, sign kept for the update
  assign diff      = {1'b0, smp} - {1'b0, ram_rdata};
  assign diff_mag  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
  assign mean_next = neg ? mean - quotient : mean + quotient;

  assign n         = N_W'(round_count) + 1'b1;
  assign count_inc = n;
  assign round_end = (ch == CH_FINAL);
  assign report    = round_end && (count_inc >= N_W'(rounds_per_report));
  assign out_free  = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ram_req       = '0;
    div_start     = 1'b0;
    scale_en      = 1'b0;
    load          = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_req.raddr = in_ch[ADDR_W-1:0];
        // drop samples of channels that do not exist
        if (in_take && ({1'b0, in_ch} < CH_LIMIT)) begin
          ram_req.rd = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_req.wr    = 1'b1;
        ram_req.waddr = ch[ADDR_W-1:0];
        ram_req.wdata = mean_next;
        state_next    = report ? ST_RPT_READ : ST_IDLE;
      end
      ST_RPT_READ: begin
        ram_req.rd    = 1'b1;
        ram_req.raddr = k;
        state_next    = ST_RPT_MUL;
      end
      ST_RPT_MUL: begin
        scale_en   = 1'b1;
        state_next = ST_RPT_LOAD;
      end
      ST_RPT_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          if (k == ADDR_LAST) begin
            ram_req.clr = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            state_next = ST_RPT_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch  <= in_ch;
      smp <= in_smp;
    end
    if (state == ST_READ) begin
      mean <= ram_rdata;
      neg  <= diff[SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds_per_report <= RPR_RESET;
      full_scale_mv     <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROUNDS_PER_REPORT: rounds_per_report <= cfg_data[COUNT_W-1:0];
        REG_FULL_SCALE_MV:     full_scale_mv     <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= '0;
      k           <= '0;
    end else begin
      if ((state == ST_WRITE) && round_end) begin
        round_count <= report ? '0 : count_inc[COUNT_W-1:0];
      end
      if (state == ST_WRITE) begin
        k <= '0;
      end else if (load) begin
        k <= k + 1'b1;
      end
    end
  end

  // output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch   <= CH_W'(k);
      out_mv   <= scaled_mv;
      out_last <= (k == ADDR_LAST);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_DATA_W - CH_W - MV_W){1'b0}}, out_mv, out_ch};

  mrmr_mean_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  mrmr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (n),
    .done     (div_done),
    .quotient (quotient)
  );

  mrmr_scale u_scale (
    .clk           (clk),
    .en            (scale_en),
    .mean          (ram_rdata),
    .full_scale_mv (full_scale_mv),
    .millivolts    (scaled_mv)
  );

endmodule

>>> src/mrmr_checker.sv
module mrmr_checker
  import mrmr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped under stall");

  // tlast marks exactly the final channel of a report
  a_last_ch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[CH_W-1:0] == CH_FINAL)))
    else $error("tlast out of step with channel");

  // no sample is taken while a report is still being emitted
  a_no_in_mid_report: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("sample accepted during report");

  // one sample in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back sample accepted");

endmodule

bind multichannel_running_mean_report mrmr_checker u_chk (.*);
